// ----- design/sldec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldec_pkg
// Shared types and constants of the string-literal name decoder: transaction
// structs, parse stages and the small character tables.
// ----------------------------------------------------------------------------
package sldec_pkg;

    localparam int PrefixLen  = 6;
    localparam int MinNameLen = 10;
    localparam int MaxResults = 5;

    localparam logic [7:0] UpperBase = 8'hC1;
    localparam logic [7:0] LowerBase = 8'hE1;
    localparam logic [7:0] ChQuest   = 8'h3F;  // '?'
    localparam logic [7:0] ChDollar  = 8'h24;  // '$'
    localparam logic [7:0] ChAt      = 8'h40;  // '@'
    localparam logic [7:0] ChZero    = 8'h30;  // '0'
    localparam logic [7:0] ChNine    = 8'h39;
    localparam logic [7:0] ChUpA     = 8'h41;
    localparam logic [7:0] ChUpP     = 8'h50;
    localparam logic [7:0] ChUpZ     = 8'h5A;
    localparam logic [7:0] ChLoA     = 8'h61;
    localparam logic [7:0] ChLoZ     = 8'h7A;

    localparam logic [1:0] StatDecoded  = 2'd0;
    localparam logic [1:0] StatNotLit   = 2'd1;
    localparam logic [1:0] StatFallback = 2'd2;

    typedef enum logic [2:0] {
        ST_PREFIX = 3'd0,
        ST_TYPE   = 3'd1,
        ST_LEN0   = 3'd2,
        ST_LENX   = 3'd3,
        ST_SUM0   = 3'd4,
        ST_SUMX   = 3'd5,
        ST_TEXT   = 3'd6,
        ST_SKIP   = 3'd7
    } stage_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       done_res;
        logic [1:0] status;
    } res_t;

    // Results caused by one input transaction, slot 0 first
    typedef struct packed {
        logic [2:0]                  cnt;
        res_t [MaxResults-1:0]       items;
    } step_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h3F;  // ?
            3'd1:    c = 8'h3F;  // ?
            3'd2:    c = 8'h5F;  // _
            3'd3:    c = 8'h43;  // C
            3'd4:    c = 8'h40;  // @
            3'd5:    c = 8'h5F;  // _
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] punct_char(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd0:    c = 8'h2C;  // comma
            4'd1:    c = 8'h2F;  // slash
            4'd2:    c = 8'h5C;  // backslash
            4'd3:    c = 8'h3A;  // colon
            4'd4:    c = 8'h2E;  // period
            4'd5:    c = 8'h20;  // space
            4'd6:    c = 8'h0A;  // newline
            4'd7:    c = 8'h09;  // tab
            4'd8:    c = 8'h27;  // apostrophe
            4'd9:    c = 8'h2D;  // dash
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

endpackage

// ----- design/string_literal_name_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_name_decoder_top
// Streaming decoder for decorated string-literal symbol names.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one character of the
//   name per transaction; in_data.last marks its final character.
//   Output channel (out_valid / out_stall / out_data) carries decoded text
//   bytes, then one closing transaction with done_res = 1 and the status.
//   A character is parsed in the cycle it is accepted and its results (zero
//   to five) sit in a result buffer from the next cycle on, one transaction
//   per cycle. A new character is accepted whenever the buffer is empty or
//   its final entry leaves in the same cycle, so a stream that releases at
//   most one byte per character runs at one character per cycle unless
//   out_stall holds it. Characters releasing several bytes (escape flush,
//   closing status) hold the input until their final entry leaves the port.
//   Reset clears the parse state and empties the buffer. When the receiver
//   stalls, the buffered transaction holds and the input stalls once the
//   buffer cannot take the next character's results.
// ----------------------------------------------------------------------------
module string_literal_name_decoder_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sldec_pkg::in_item_t in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output sldec_pkg::res_t     out_data
);

    sldec_pkg::step_t step;
    sldec_pkg::res_t [sldec_pkg::MaxResults-1:0] items_reg, items_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       in_take, out_take;

    sldec_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (in_take),
        .item  (in_data),
        .step  (step)
    );

    // Handshake: accept when the buffer is empty or drains this cycle
    assign out_valid = (cnt_reg != 3'd0);
    assign out_take  = out_valid && !out_stall;
    assign in_stall  = !((cnt_reg == 3'd0) || (cnt_reg == 3'd1 && !out_stall));
    assign in_take   = in_valid && !in_stall;
    assign out_data  = items_reg[0];

    // Load new results or advance the buffer by one entry
    always_comb
    begin
        items_next = items_reg;
        cnt_next   = cnt_reg;
        if (in_take)
        begin
            items_next = step.items;
            cnt_next   = step.cnt;
        end
        else if (out_take)
        begin
            for (int i = 0; i < sldec_pkg::MaxResults - 1; i++)
            begin
                items_next[i] = items_reg[i+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

    // Buffer never holds more than one character's results
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(sldec_pkg::MaxResults))
        else $error("result buffer count out of range");

    // A character is taken only when no earlier result would be overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> (cnt_reg == 3'd0 || (cnt_reg == 3'd1 && out_take)))
        else $error("input accepted over pending results");

    // The closing transaction is always the final buffered entry
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.done_res) |-> (cnt_reg == 3'd1 && out_data.out_char == 8'h00))
        else $error("closing transaction not last or carries a byte");

    // Text bytes carry a zero status
    a_text_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.done_res) |-> (out_data.status == sldec_pkg::StatDecoded))
        else $error("text byte with nonzero status");

endmodule

// ----- design/sldec_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldec_core
// Parse state of the decoder. Works out, from the held state and one input
// character, the result transactions it causes and the next parse state.
// ----------------------------------------------------------------------------
module sldec_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  sldec_pkg::in_item_t item,
    output sldec_pkg::step_t    step
);

    sldec_pkg::stage_t stage_reg, stage_next;
    logic [2:0] prefix_pos_reg, prefix_pos_next;
    logic [3:0] char_count_reg, char_count_next;
    logic       len_nz_reg, len_nz_next;
    logic       sum_nz_reg, sum_nz_next;
    logic       fallback_reg, fallback_next;
    logic [7:0] pend2_reg, pend2_next;
    logic [1:0] pend_cnt_reg, pend_cnt_next;
    logic       nonblank_reg, nonblank_next;
    logic       text_end_reg, text_end_next;
    logic       zero_seen_reg, zero_seen_next;

    logic [7:0] bytes [sldec_pkg::MaxResults];
    logic [2:0] nb;
    logic [2:0] nb_text;
    logic [1:0] status;

    logic [7:0] ch;
    logic       is_hex, is_digit, is_upper, is_lower;
    logic       is_len, first_fld, nz_cur, nz_new;
    sldec_pkg::stage_t hex_st, done_st;
    logic       plain_end, plain_pend;

    assign ch        = item.ch;
    assign is_hex    = (ch >= sldec_pkg::ChUpA) && (ch <= sldec_pkg::ChUpP);
    assign is_digit  = (ch >= sldec_pkg::ChZero) && (ch <= sldec_pkg::ChNine);
    assign is_upper  = (ch >= sldec_pkg::ChUpA) && (ch <= sldec_pkg::ChUpZ);
    assign is_lower  = (ch >= sldec_pkg::ChLoA) && (ch <= sldec_pkg::ChLoZ);
    assign plain_end  = (ch == sldec_pkg::ChAt) || (ch == 8'h00);
    assign plain_pend = (ch == sldec_pkg::ChQuest);

    // Field stage selection: length field or checksum field
    assign is_len    = (stage_reg == sldec_pkg::ST_LEN0) || (stage_reg == sldec_pkg::ST_LENX);
    assign first_fld = (stage_reg == sldec_pkg::ST_LEN0) || (stage_reg == sldec_pkg::ST_SUM0);
    assign nz_cur    = is_len ? len_nz_reg : sum_nz_reg;
    assign hex_st    = is_len ? sldec_pkg::ST_LENX : sldec_pkg::ST_SUMX;
    assign done_st   = is_len ? sldec_pkg::ST_SUM0 : sldec_pkg::ST_TEXT;

    // Next parse state and the text bytes this character releases
    always_comb
    begin : decode
        stage_next      = stage_reg;
        prefix_pos_next = prefix_pos_reg;
        char_count_next = (char_count_reg < 4'(sldec_pkg::MinNameLen))
                          ? char_count_reg + 4'd1 : char_count_reg;
        len_nz_next     = len_nz_reg;
        sum_nz_next     = sum_nz_reg;
        fallback_next   = fallback_reg;
        pend2_next      = pend2_reg;
        pend_cnt_next   = pend_cnt_reg;
        text_end_next   = text_end_reg;
        nz_new          = nz_cur;
        nb_text         = 3'd0;
        for (int i = 0; i < sldec_pkg::MaxResults; i++)
        begin
            bytes[i] = 8'h00;
        end

        case (stage_reg)
            sldec_pkg::ST_PREFIX:
            begin
                if (prefix_pos_reg < 3'(sldec_pkg::PrefixLen) &&
                    ch == sldec_pkg::prefix_char(prefix_pos_reg))
                begin
                    prefix_pos_next = prefix_pos_reg + 3'd1;
                    if (prefix_pos_reg == 3'(sldec_pkg::PrefixLen - 1))
                    begin
                        stage_next = sldec_pkg::ST_TYPE;
                    end
                end
                else
                begin
                    stage_next = sldec_pkg::ST_SKIP;
                end
            end
            sldec_pkg::ST_TYPE:
            begin
                if (ch == sldec_pkg::ChZero)
                begin
                    stage_next = sldec_pkg::ST_LEN0;
                end
                else
                begin
                    stage_next    = sldec_pkg::ST_SKIP;
                    fallback_next = 1'b1;
                end
            end
            sldec_pkg::ST_LEN0, sldec_pkg::ST_LENX,
            sldec_pkg::ST_SUM0, sldec_pkg::ST_SUMX:
            begin
                if (first_fld && is_digit)
                begin
                    nz_new = (ch != sldec_pkg::ChZero);
                    if (nz_new)
                    begin
                        stage_next = done_st;
                    end
                    else
                    begin
                        stage_next    = sldec_pkg::ST_SKIP;
                        fallback_next = 1'b1;
                    end
                end
                else if (is_hex)
                begin
                    if (ch != sldec_pkg::ChUpA)
                    begin
                        nz_new = 1'b1;
                    end
                    stage_next = hex_st;
                end
                else if (ch == sldec_pkg::ChAt && nz_cur)
                begin
                    stage_next = done_st;
                end
                else
                begin
                    stage_next    = sldec_pkg::ST_SKIP;
                    fallback_next = 1'b1;
                end
                if (is_len)
                begin
                    len_nz_next = nz_new;
                end
                else
                begin
                    sum_nz_next = nz_new;
                end
            end
            sldec_pkg::ST_TEXT:
            begin
                if (!text_end_reg)
                begin
                    if (pend_cnt_reg == 2'd1 && ch == sldec_pkg::ChDollar)
                    begin
                        pend_cnt_next = 2'd2;
                    end
                    else if (pend_cnt_reg == 2'd1 && (is_digit || is_upper || is_lower))
                    begin
                        pend_cnt_next = 2'd0;
                        if (is_digit)
                        begin
                            bytes[0] = sldec_pkg::punct_char(4'(ch - sldec_pkg::ChZero));
                        end
                        else if (is_upper)
                        begin
                            bytes[0] = 8'(ch - sldec_pkg::ChUpA + sldec_pkg::UpperBase);
                        end
                        else
                        begin
                            bytes[0] = 8'(ch - sldec_pkg::ChLoA + sldec_pkg::LowerBase);
                        end
                        nb_text = 3'd1;
                    end
                    else if (pend_cnt_reg == 2'd2 && is_hex)
                    begin
                        pend2_next    = ch;
                        pend_cnt_next = 2'd3;
                    end
                    else if (pend_cnt_reg == 2'd3 && is_hex)
                    begin
                        pend_cnt_next = 2'd0;
                        bytes[0] = {4'(pend2_reg - sldec_pkg::ChUpA),
                                    4'(ch - sldec_pkg::ChUpA)};
                        nb_text = 3'd1;
                    end
                    else
                    begin
                        // Release held escape characters, then take ch as text, end mark or escape start
                        if (pend_cnt_reg >= 2'd1)
                        begin
                            bytes[0] = sldec_pkg::ChQuest;
                        end
                        if (pend_cnt_reg >= 2'd2)
                        begin
                            bytes[1] = sldec_pkg::ChDollar;
                        end
                        if (pend_cnt_reg == 2'd3)
                        begin
                            bytes[2] = pend2_reg;
                        end
                        nb_text = {1'b0, pend_cnt_reg};
                        pend_cnt_next = 2'd0;
                        if (plain_end)
                        begin
                            text_end_next = 1'b1;
                        end
                        else if (plain_pend)
                        begin
                            pend_cnt_next = 2'd1;
                        end
                        else
                        begin
                            bytes[nb_text] = ch;
                            nb_text = nb_text + 3'd1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Final flush, blank-text tracking and the closing status
    always_comb
    begin : results
        nb             = nb_text;
        status         = sldec_pkg::StatDecoded;
        nonblank_next  = nonblank_reg;
        zero_seen_next = zero_seen_reg;
        step           = '0;

        if (item.last)
        begin
            if (char_count_next < 4'(sldec_pkg::MinNameLen) ||
                (stage_next == sldec_pkg::ST_SKIP && !fallback_next))
            begin
                status = sldec_pkg::StatNotLit;
            end
            else if (stage_next != sldec_pkg::ST_TEXT)
            begin
                status = sldec_pkg::StatFallback;
            end
            else
            begin
                if (pend_cnt_next >= 2'd1)
                begin
                    step.items[nb].out_char = sldec_pkg::ChQuest;
                    nb = nb + 3'd1;
                end
                if (pend_cnt_next >= 2'd2)
                begin
                    step.items[nb].out_char = sldec_pkg::ChDollar;
                    nb = nb + 3'd1;
                end
                if (pend_cnt_next == 2'd3)
                begin
                    step.items[nb].out_char = pend2_next;
                    nb = nb + 3'd1;
                end
            end
        end

        for (int i = 0; i < sldec_pkg::MaxResults; i++)
        begin
            if (3'(i) < nb_text)
            begin
                step.items[i].out_char = bytes[i];
            end
        end

        // Walk the released bytes in order
        for (int i = 0; i < sldec_pkg::MaxResults; i++)
        begin
            if (3'(i) < nb)
            begin
                if (step.items[i].out_char == 8'h00)
                begin
                    zero_seen_next = 1'b1;
                end
                else if (!zero_seen_next && !sldec_pkg::is_space(step.items[i].out_char))
                begin
                    nonblank_next = 1'b1;
                end
            end
        end

        if (item.last)
        begin
            if (status == sldec_pkg::StatDecoded && !nonblank_next)
            begin
                status = sldec_pkg::StatFallback;
            end
            step.items[nb].out_char = 8'h00;
            step.items[nb].done_res = 1'b1;
            step.items[nb].status   = status;
            step.cnt = nb + 3'd1;
        end
        else
        begin
            step.cnt = nb;
        end
    end

    // Advance parse state on each accepted character; clear after the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg      <= sldec_pkg::ST_PREFIX;
            prefix_pos_reg <= '0;
            char_count_reg <= '0;
            len_nz_reg     <= 1'b0;
            sum_nz_reg     <= 1'b0;
            fallback_reg   <= 1'b0;
            pend_cnt_reg   <= '0;
            nonblank_reg   <= 1'b0;
            text_end_reg   <= 1'b0;
            zero_seen_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (item.last)
            begin
                stage_reg      <= sldec_pkg::ST_PREFIX;
                prefix_pos_reg <= '0;
                char_count_reg <= '0;
                len_nz_reg     <= 1'b0;
                sum_nz_reg     <= 1'b0;
                fallback_reg   <= 1'b0;
                pend_cnt_reg   <= '0;
                nonblank_reg   <= 1'b0;
                text_end_reg   <= 1'b0;
                zero_seen_reg  <= 1'b0;
            end
            else
            begin
                stage_reg      <= stage_next;
                prefix_pos_reg <= prefix_pos_next;
                char_count_reg <= char_count_next;
                len_nz_reg     <= len_nz_next;
                sum_nz_reg     <= sum_nz_next;
                fallback_reg   <= fallback_next;
                pend_cnt_reg   <= pend_cnt_next;
                nonblank_reg   <= nonblank_next;
                text_end_reg   <= text_end_next;
                zero_seen_reg  <= zero_seen_next;
            end
        end
    end

    // Hold the escape hex letter; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend2_reg <= pend2_next;
        end
    end

endmodule
